@@ rtl/gha_pkg.sv @@
package gha_pkg;

   // default build parameters
   localparam int AVG_DEPTH_DEF   = 100;
   localparam int SAMPLE_BITS_DEF = 12;
   localparam int KEY_COUNT_DEF   = 4;

   // widest key pattern the code compare supports
   localparam int KEY_MAX = 8;

   // register field widths
   localparam int LIMIT_W   = 20;
   localparam int BLINK_W   = 10;
   localparam int CODE_W    = 4;
   localparam int ATTEMPT_W = 3;
   localparam int FAIL_W    = 3;

   // register port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   localparam logic [CSR_INDEX_W-1:0] CSR_OVER_TEMP_LIMIT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAS_BLINK       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAT_BLINK      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOTH_BLINK      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNLOCK_CODE     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ATTEMPT_LIMIT   = 3'd5;

   // register reset values (limit is 50 C averaged over 100 samples)
   localparam logic [LIMIT_W-1:0]   OVER_TEMP_LIMIT_RST = 20'd62045;
   localparam logic [BLINK_W-1:0]   GAS_BLINK_RST       = 10'd100;
   localparam logic [BLINK_W-1:0]   HEAT_BLINK_RST      = 10'd50;
   localparam logic [BLINK_W-1:0]   BOTH_BLINK_RST      = 10'd10;
   localparam logic [CODE_W-1:0]    UNLOCK_CODE_RST     = 4'd3;
   localparam logic [ATTEMPT_W-1:0] ATTEMPT_LIMIT_RST   = 3'd5;

   // blink counter saturates here
   localparam logic [BLINK_W-1:0] BLINK_MAX = '1;

   // configuration as seen by the alarm logic
   typedef struct packed {
      logic [LIMIT_W-1:0]   over_temp_sum_limit;
      logic [BLINK_W-1:0]   gas_blink_ticks;
      logic [BLINK_W-1:0]   heat_blink_ticks;
      logic [BLINK_W-1:0]   both_blink_ticks;
      logic [CODE_W-1:0]    unlock_code;
      logic [ATTEMPT_W-1:0] attempt_limit;
   } csr_type;

   // pipeline transfer strobes
   typedef struct packed {
      logic accept;   // input transfer, ring read issued
      logic adv_b;    // averaging stage moves into the alarm stage
      logic adv_c;    // alarm stage updates state and loads the result
   } pipe_en_type;

endpackage

@@ rtl/gha_avg.sv @@
module gha_avg
   import gha_pkg::*;
#(
   parameter int AVG_DEPTH   = AVG_DEPTH_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int KEY_COUNT   = KEY_COUNT_DEF,
   parameter int SUM_W       = SAMPLE_BITS + $clog2(AVG_DEPTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pipe_en_type            pipe,
   input  logic [SAMPLE_BITS-1:0] req_temp_sample,
   input  logic                   req_gas_line,
   input  logic                   req_test_button,
   input  logic [KEY_COUNT-1:0]   req_keys,
   input  logic                   req_enter_key,
   output logic                   b_gas_line,
   output logic                   b_test_button,
   output logic [KEY_COUNT-1:0]   b_keys,
   output logic                   b_enter_key,
   output logic [SUM_W-1:0]       sum
);

   localparam int POS_W = $clog2(AVG_DEPTH);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(AVG_DEPTH - 1);
   localparam logic [SUM_W-1:0] SUM_MAX =
      SUM_W'(AVG_DEPTH * ((1 << SAMPLE_BITS) - 1));

   // sample ring, one read and one write port: read at transfer, written back a stage later
   logic [SAMPLE_BITS-1:0] ring_mem [AVG_DEPTH];

   logic [POS_W-1:0]       ring_pos_ff, ring_pos_in;
   logic                   ring_full_ff;
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic [SAMPLE_BITS-1:0] sample_b_ff;
   logic [POS_W-1:0]       addr_b_ff;
   logic                   full_b_ff;
   logic                   gas_b_ff, test_b_ff, enter_b_ff;
   logic [KEY_COUNT-1:0]   keys_b_ff;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0] old_sample;

   // write position walks the ring
   assign ring_pos_in = (ring_pos_ff == POS_LAST) ? '0 : ring_pos_ff + POS_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_pos_ff  <= '0;
         ring_full_ff <= 1'b0;
      end else if (pipe.accept) begin
         ring_pos_ff <= ring_pos_in;
         if (ring_pos_ff == POS_LAST) begin
            ring_full_ff <= 1'b1;
         end
      end
   end

   // ring memory: read old entry on transfer, write new sample on advance
   always_ff @(posedge clock) begin
      if (pipe.accept) begin
         rd_data_ff <= ring_mem[ring_pos_ff];
      end
      if (pipe.adv_b) begin
         ring_mem[addr_b_ff] <= sample_b_ff;
      end
   end

   // stage B payload
   always_ff @(posedge clock) begin
      if (pipe.accept) begin
         sample_b_ff <= req_temp_sample;
         addr_b_ff   <= ring_pos_ff;
         full_b_ff   <= ring_full_ff;
         gas_b_ff    <= req_gas_line;
         test_b_ff   <= req_test_button;
         keys_b_ff   <= req_keys;
         enter_b_ff  <= req_enter_key;
      end
   end

   // entries not yet written since reset count as zero
   assign old_sample = full_b_ff ? rd_data_ff : '0;
   assign sum_in     = sum_ff + SUM_W'(sample_b_ff) - SUM_W'(old_sample);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (pipe.adv_b) begin
         sum_ff <= sum_in;
      end
   end

   assign b_gas_line    = gas_b_ff;
   assign b_test_button = test_b_ff;
   assign b_keys        = keys_b_ff;
   assign b_enter_key   = enter_b_ff;
   assign sum           = sum_ff;

`ifndef ASSERT_OFF
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      ring_pos_ff <= POS_LAST)
      else $error("ring position beyond ring depth");

   a_full_at_wrap: assert property (@(posedge clock) disable iff (reset)
      $rose(ring_full_ff) |-> ring_pos_ff == '0)
      else $error("ring marked full away from the wrap point");

   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      sum_ff <= SUM_MAX)
      else $error("running sum exceeds a full ring of maximum samples");
`endif

endmodule

@@ rtl/gha_ctrl.sv @@
module gha_ctrl
   import gha_pkg::*;
#(
   parameter int KEY_COUNT = KEY_COUNT_DEF,
   parameter int SUM_W     = SAMPLE_BITS_DEF + $clog2(AVG_DEPTH_DEF)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pipe_en_type          pipe,
   input  csr_type              csr,
   input  logic                 b_gas_line,
   input  logic                 b_test_button,
   input  logic [KEY_COUNT-1:0] b_keys,
   input  logic                 b_enter_key,
   input  logic [SUM_W-1:0]     sum,
   output logic                 rsp_siren_on,
   output logic                 rsp_blink_led,
   output logic                 rsp_wrong_code_led,
   output logic                 rsp_locked_led,
   output logic                 rsp_over_temp,
   output logic                 rsp_alarm_active
);

   localparam int CMP_W = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;

   // stage C payload
   logic                 gas_line_c_ff, test_c_ff, enter_c_ff;
   logic [KEY_COUNT-1:0] keys_c_ff;

   // alarm and lock state
   logic               alarm_ff, alarm_in;
   logic               gas_lat_ff, gas_lat_in;
   logic               heat_lat_ff, heat_lat_in;
   logic [BLINK_W-1:0] blink_ff, blink_in;
   logic               phase_ff, phase_in;
   logic               siren_ff, siren_in;
   logic               err_ff, err_in;
   logic               lock_ff, lock_in;
   logic [FAIL_W-1:0]  fail_ff, fail_in;

   // result register
   logic rsp_siren_ff, rsp_phase_ff, rsp_err_ff, rsp_lock_ff, rsp_over_ff, rsp_alarm_ff;

   logic               over, gas, alarm_mid;
   logic               gas_cause, heat_cause;
   logic [BLINK_W-1:0] blink_up, period;
   logic [KEY_MAX-1:0] code_ext;
   logic [KEY_COUNT-1:0] code_k;

   always_ff @(posedge clock) begin
      if (pipe.adv_b) begin
         gas_line_c_ff <= b_gas_line;
         test_c_ff     <= b_test_button;
         keys_c_ff     <= b_keys;
         enter_c_ff    <= b_enter_key;
      end
   end

   // sum in the register is this item's sum while it sits in stage C
   assign over     = CMP_W'(sum) > CMP_W'(csr.over_temp_sum_limit);
   assign gas      = ~gas_line_c_ff;
   assign code_ext = KEY_MAX'(csr.unlock_code);
   assign code_k   = code_ext[KEY_COUNT-1:0];
   assign blink_up = (blink_ff < BLINK_MAX) ? blink_ff + BLINK_W'(1) : blink_ff;

   // causes latched by this tick
   assign gas_cause  = gas_lat_ff | gas | test_c_ff;
   assign heat_cause = heat_lat_ff | over | test_c_ff;

   // blink period from the latched causes
   always_comb begin
      if (gas_cause && heat_cause) begin
         period = csr.both_blink_ticks;
      end else if (gas_cause) begin
         period = csr.gas_blink_ticks;
      end else begin
         period = csr.heat_blink_ticks;
      end
   end

   // alarm part, then code part
   always_comb begin
      alarm_mid   = alarm_ff | gas | over | test_c_ff;
      gas_lat_in  = gas_cause;
      heat_lat_in = heat_cause;
      blink_in    = blink_ff;
      phase_in    = phase_ff;
      siren_in    = siren_ff;
      if (alarm_mid) begin
         siren_in = 1'b1;
         blink_in = blink_up;
         if ((gas_cause || heat_cause) && blink_up >= period) begin
            blink_in = '0;
            phase_in = ~phase_ff;
         end
      end else begin
         phase_in    = 1'b0;
         gas_lat_in  = 1'b0;
         heat_lat_in = 1'b0;
         siren_in    = 1'b0;
      end

      alarm_in = alarm_mid;
      err_in   = err_ff;
      fail_in  = fail_ff;
      lock_in  = lock_ff;
      if (fail_ff < csr.attempt_limit) begin
         if ((&keys_c_ff) && !enter_c_ff) begin
            err_in = 1'b0;
         end
         if (enter_c_ff && !err_ff && alarm_mid) begin
            if (keys_c_ff == code_k) begin
               alarm_in = 1'b0;
               fail_in  = '0;
            end else begin
               err_in  = 1'b1;
               fail_in = fail_ff + FAIL_W'(1);
            end
         end
      end else begin
         lock_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alarm_ff    <= 1'b0;
         gas_lat_ff  <= 1'b0;
         heat_lat_ff <= 1'b0;
         blink_ff    <= '0;
         phase_ff    <= 1'b0;
         siren_ff    <= 1'b0;
         err_ff      <= 1'b0;
         lock_ff     <= 1'b0;
         fail_ff     <= '0;
      end else if (pipe.adv_c) begin
         alarm_ff    <= alarm_in;
         gas_lat_ff  <= gas_lat_in;
         heat_lat_ff <= heat_lat_in;
         blink_ff    <= blink_in;
         phase_ff    <= phase_in;
         siren_ff    <= siren_in;
         err_ff      <= err_in;
         lock_ff     <= lock_in;
         fail_ff     <= fail_in;
      end
   end

   // result register, held while the consumer stalls
   always_ff @(posedge clock) begin
      if (pipe.adv_c) begin
         rsp_siren_ff <= siren_in;
         rsp_phase_ff <= phase_in;
         rsp_err_ff   <= err_in;
         rsp_lock_ff  <= lock_in;
         rsp_over_ff  <= over;
         rsp_alarm_ff <= alarm_in;
      end
   end

   assign rsp_siren_on       = rsp_siren_ff;
   assign rsp_blink_led      = rsp_phase_ff;
   assign rsp_wrong_code_led = rsp_err_ff;
   assign rsp_locked_led     = rsp_lock_ff;
   assign rsp_over_temp      = rsp_over_ff;
   assign rsp_alarm_active   = rsp_alarm_ff;

`ifndef ASSERT_OFF
   a_lock_sticky: assert property (@(posedge clock) disable iff (reset)
      lock_ff |=> lock_ff)
      else $error("lock released without reset");

   a_alarm_has_cause: assert property (@(posedge clock) disable iff (reset)
      alarm_ff |-> (gas_lat_ff || heat_lat_ff))
      else $error("alarm set with no cause latched");

   a_alarm_siren: assert property (@(posedge clock) disable iff (reset)
      $past(pipe.adv_c) && alarm_ff |-> siren_ff)
      else $error("alarm active without siren");
`endif

endmodule

@@ rtl/gas_heat_alarm_with_code_lock_unit.sv @@
// Result path: the input transfer issues the ring read, then the sum update, then the
//   result register raises rsp_valid; rsp_stall can hold the pipe between these steps.
// Throughput: one tick per cycle unless rsp_stall holds the pipe; the ring RAM is read
//   at the input transfer and the same entry is written back as the tick leaves the
//   averaging stage, always at a different address than the next tick reads.
// Reset: synchronous; clears alarm, lock and counter state, the running sum
//   and the ring fill flag, and loads the register defaults. No clearing pass.
module gas_heat_alarm_with_code_lock_unit
   import gha_pkg::*;
#(
   parameter int AVG_DEPTH   = AVG_DEPTH_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int KEY_COUNT   = KEY_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_temp_sample,
   input  logic                   req_gas_line,
   input  logic                   req_test_button,
   input  logic [KEY_COUNT-1:0]   req_keys,
   input  logic                   req_enter_key,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_siren_on,
   output logic                   rsp_blink_led,
   output logic                   rsp_wrong_code_led,
   output logic                   rsp_locked_led,
   output logic                   rsp_over_temp,
   output logic                   rsp_alarm_active
);

   localparam int SUM_W = SAMPLE_BITS + $clog2(AVG_DEPTH);

   csr_type     csr_ff;
   pipe_en_type pipe;

   logic valid_b_ff, valid_c_ff, rsp_valid_ff;
   logic en_out, en_c, en_b;

   logic                 b_gas_line, b_test_button, b_enter_key;
   logic [KEY_COUNT-1:0] b_keys;
   logic [SUM_W-1:0]     sum;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.over_temp_sum_limit <= OVER_TEMP_LIMIT_RST;
         csr_ff.gas_blink_ticks     <= GAS_BLINK_RST;
         csr_ff.heat_blink_ticks    <= HEAT_BLINK_RST;
         csr_ff.both_blink_ticks    <= BOTH_BLINK_RST;
         csr_ff.unlock_code         <= UNLOCK_CODE_RST;
         csr_ff.attempt_limit       <= ATTEMPT_LIMIT_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_OVER_TEMP_LIMIT: csr_ff.over_temp_sum_limit <= csr_wdata[LIMIT_W-1:0];
            CSR_GAS_BLINK:       csr_ff.gas_blink_ticks     <= csr_wdata[BLINK_W-1:0];
            CSR_HEAT_BLINK:      csr_ff.heat_blink_ticks    <= csr_wdata[BLINK_W-1:0];
            CSR_BOTH_BLINK:      csr_ff.both_blink_ticks    <= csr_wdata[BLINK_W-1:0];
            CSR_UNLOCK_CODE:     csr_ff.unlock_code         <= csr_wdata[CODE_W-1:0];
            CSR_ATTEMPT_LIMIT:   csr_ff.attempt_limit       <= csr_wdata[ATTEMPT_W-1:0];
            default: ;
         endcase
      end
   end

   // stage enables: a stage moves when the next one is empty or moving
   assign en_out    = ~rsp_valid_ff | ~rsp_stall;
   assign en_c      = ~valid_c_ff | en_out;
   assign en_b      = ~valid_b_ff | en_c;
   assign req_stall = ~en_b;

   assign pipe.accept = req_valid & en_b;
   assign pipe.adv_b  = valid_b_ff & en_c;
   assign pipe.adv_c  = valid_c_ff & en_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff   <= 1'b0;
         valid_c_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en_b) begin
            valid_b_ff <= pipe.accept;
         end
         if (en_c) begin
            valid_c_ff <= valid_b_ff;
         end
         if (en_out) begin
            rsp_valid_ff <= valid_c_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   gha_avg #(
      .AVG_DEPTH   (AVG_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS),
      .KEY_COUNT   (KEY_COUNT),
      .SUM_W       (SUM_W)
   ) u_avg (
      .clock           (clock),
      .reset           (reset),
      .pipe            (pipe),
      .req_temp_sample (req_temp_sample),
      .req_gas_line    (req_gas_line),
      .req_test_button (req_test_button),
      .req_keys        (req_keys),
      .req_enter_key   (req_enter_key),
      .b_gas_line      (b_gas_line),
      .b_test_button   (b_test_button),
      .b_keys          (b_keys),
      .b_enter_key     (b_enter_key),
      .sum             (sum)
   );

   gha_ctrl #(
      .KEY_COUNT (KEY_COUNT),
      .SUM_W     (SUM_W)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .pipe               (pipe),
      .csr                (csr_ff),
      .b_gas_line         (b_gas_line),
      .b_test_button      (b_test_button),
      .b_keys             (b_keys),
      .b_enter_key        (b_enter_key),
      .sum                (sum),
      .rsp_siren_on       (rsp_siren_on),
      .rsp_blink_led      (rsp_blink_led),
      .rsp_wrong_code_led (rsp_wrong_code_led),
      .rsp_locked_led     (rsp_locked_led),
      .rsp_over_temp      (rsp_over_temp),
      .rsp_alarm_active   (rsp_alarm_active)
   );

`ifndef ASSERT_OFF
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      pipe.adv_c |=> rsp_valid_ff)
      else $error("alarm stage transfer lost before the result register");

   a_b_fed: assert property (@(posedge clock) disable iff (reset)
      pipe.accept |=> valid_b_ff)
      else $error("input transfer not captured in the averaging stage");

   a_c_fed: assert property (@(posedge clock) disable iff (reset)
      pipe.adv_b |=> valid_c_ff)
      else $error("averaging stage transfer lost before the alarm stage");
`endif

endmodule
